// File: hdl/irmw_pkg.sv
// ----------------------------------------------------------------------------
// irmw_pkg: shared types and constants
// Widths, conversion constants and controller/datapath command types.
// ----------------------------------------------------------------------------
package irmw_pkg;

   localparam int SAMPLE_W    = 10;
   localparam int RANGE_W     = 14;
   localparam int CLAMP_W     = 7;
   localparam int MEAN_W      = 14;
   localparam int SPREAD_W    = 14;
   localparam int STDEV_W     = 13;
   localparam int WINDOW_LEN_DEF = 16;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 10'd22;
   localparam logic [12:0]  CONV_MUL    = 13'd7836;
   localparam logic [22:0]  CONV_OFS    = 23'd166052;
   localparam logic [16:0]  RANGE_NUM   = 17'd65535;
   localparam logic [RANGE_W-1:0] CLAMP_HI = 14'd80;
   localparam logic [RANGE_W-1:0] CLAMP_LO = 14'd10;

   // commands from controller to datapath
   typedef struct packed {
      logic load;        // capture sample, start conversion
      logic div_step;    // one quotient bit of the reciprocal division
      logic median;      // median, shift taps, write window
      logic rd_addr_clr; // restart window read address
      logic rd_issue;    // advance window read address
      logic acc_clr;     // clear accumulators for a pass
      logic acc1;        // accumulate sum/min/max
      logic mean_calc;   // latch mean
      logic acc2;        // accumulate squared deviation
      logic sq_div;      // latch mean squared deviation, init isqrt
      logic sqrt_step;   // one isqrt iteration
      logic clr_step;    // clear one window entry
      logic out_load;    // load result register
   } ctl_type;

   typedef struct packed {
      logic rd_last;     // read address at final entry
   } sts_type;

endpackage

// File: hdl/irmw_if.sv
// ----------------------------------------------------------------------------
// irmw_req_if / irmw_rsp_if: valid/ready channels
// One word per handshake.
// ----------------------------------------------------------------------------
interface irmw_req_if;
   import irmw_pkg::*;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] raw_sample;
   modport source (output valid, output raw_sample, input ready);
   modport sink   (input valid, input raw_sample, output ready);
endinterface

interface irmw_rsp_if;
   import irmw_pkg::*;
   logic                valid;
   logic                ready;
   logic [CLAMP_W-1:0]  range_clamped;
   logic [MEAN_W-1:0]   window_mean;
   logic [SPREAD_W-1:0] window_spread;
   logic [STDEV_W-1:0]  window_stdev;
   modport source (output valid, output range_clamped, output window_mean,
                   output window_spread, output window_stdev, input ready);
   modport sink   (input valid, input range_clamped, input window_mean,
                   input window_spread, input window_stdev, output ready);
endinterface

// File: hdl/irmw_ram.sv
// ----------------------------------------------------------------------------
// irmw_ram: generic single-port-write, single-read RAM
// Registered read data.
// ----------------------------------------------------------------------------
module irmw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// File: hdl/irmw_datapath.sv
// ----------------------------------------------------------------------------
// irmw_datapath: conversion, median, window and statistics datapath
// Bit-serial divide and isqrt, one window entry per cycle per pass.
// ----------------------------------------------------------------------------
module irmw_datapath #(
   parameter int WINDOW_LEN = irmw_pkg::WINDOW_LEN_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  irmw_pkg::ctl_type             ctl,
   output irmw_pkg::sts_type             sts,
   input  logic [irmw_pkg::SAMPLE_W-1:0] raw_sample,
   output logic [irmw_pkg::CLAMP_W-1:0]  range_clamped,
   output logic [irmw_pkg::MEAN_W-1:0]   window_mean,
   output logic [irmw_pkg::SPREAD_W-1:0] window_spread,
   output logic [irmw_pkg::STDEV_W-1:0]  window_stdev
);
   import irmw_pkg::*;

   localparam int AW     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   localparam int SUM_W  = RANGE_W + AW + 1;
   localparam int SQ_W   = 2*RANGE_W + AW + 1;
   localparam int SQRT_W = RANGE_W;
   localparam logic [AW-1:0] LAST = AW'(WINDOW_LEN - 1);

   // --- conversion -----------------------------------------------------
   logic [SAMPLE_W-1:0] s_cl;
   logic [23:0]         prod;
   logic [13:0]         q_div;
   assign s_cl  = (raw_sample < SAMPLE_MIN) ? SAMPLE_MIN : raw_sample;
   assign prod  = 24'(s_cl) * 24'(CONV_MUL) - 24'(CONV_OFS);
   assign q_div = prod[23:10];

   // restoring divider: 65535 / divisor, 17 quotient bits
   logic [16:0] dvd_ff, dvd_in;
   logic [13:0] dvs_ff, dvs_in;
   logic [14:0] rem_ff, rem_in;
   logic [15:0] trial;
   always_comb begin
      dvd_in = dvd_ff;
      dvs_in = dvs_ff;
      rem_in = rem_ff;
      trial  = {rem_ff, dvd_ff[16]} - {2'b0, dvs_ff};
      if (ctl.load) begin
         dvd_in = RANGE_NUM;
         dvs_in = q_div;
         rem_in = '0;
      end else if (ctl.div_step) begin
         if (!trial[15]) begin
            rem_in = trial[14:0];
            dvd_in = {dvd_ff[15:0], 1'b1};
         end else begin
            rem_in = {rem_ff[13:0], dvd_ff[16]};
            dvd_in = {dvd_ff[15:0], 1'b0};
         end
      end
   end
   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   // --- median and taps -----------------------------------------------
   logic [RANGE_W-1:0] r_new, prev_ff, older_ff, med_ff;
   logic [RANGE_W-1:0] lo, hi, mm, med;
   logic [AW-1:0]      wslot_ff;
   logic [AW-1:0]      clr_ff;
   assign r_new = dvd_ff[RANGE_W-1:0];
   assign lo  = (r_new < prev_ff) ? r_new : prev_ff;
   assign hi  = (r_new < prev_ff) ? prev_ff : r_new;
   assign mm  = (hi < older_ff) ? hi : older_ff;
   assign med = (lo > mm) ? lo : mm;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         older_ff <= '0;
         wslot_ff <= '0;
         clr_ff   <= '0;
      end else begin
         if (ctl.median) begin
            older_ff <= prev_ff;
            prev_ff  <= r_new;
            med_ff   <= med;
            wslot_ff <= (wslot_ff == LAST) ? '0 : wslot_ff + 1'b1;
         end
         if (ctl.clr_step) begin
            clr_ff <= (clr_ff == LAST) ? '0 : clr_ff + 1'b1;
         end
      end
   end

   // --- window memory -------------------------------------------------
   logic               wr_en;
   logic [AW-1:0]      wr_addr, rd_ff;
   logic [RANGE_W-1:0] wr_data, rd_data;
   assign wr_en   = ctl.median | ctl.clr_step;
   assign wr_addr = ctl.clr_step ? clr_ff : wslot_ff;
   assign wr_data = ctl.clr_step ? '0 : med;

   irmw_ram #(.WIDTH(RANGE_W), .DEPTH(WINDOW_LEN)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_ff),
      .rd_data (rd_data)
   );

   // read address runs in step with the clear address after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= '0;
      end else if (ctl.rd_addr_clr) begin
         rd_ff <= '0;
      end else if (ctl.rd_issue) begin
         rd_ff <= (rd_ff == LAST) ? '0 : rd_ff + 1'b1;
      end
   end
   assign sts.rd_last = (rd_ff == LAST);

   // --- statistics ----------------------------------------------------
   logic [SUM_W-1:0]   sum_ff;
   logic [RANGE_W-1:0] mx_ff, mn_ff, mean_ff;
   logic [SQ_W-1:0]    sq_ff;
   logic [RANGE_W-1:0] dev;
   logic [2*RANGE_W-1:0] dsq;
   assign dev = (rd_data >= mean_ff) ? rd_data - mean_ff : mean_ff - rd_data;
   assign dsq = dev * dev;

   always_ff @(posedge clock) begin
      if (ctl.acc_clr) begin
         sum_ff <= '0;
         sq_ff  <= '0;
         mx_ff  <= '0;
         mn_ff  <= '1;
      end else if (ctl.acc1) begin
         sum_ff <= sum_ff + SUM_W'(rd_data);
         if (rd_data > mx_ff) mx_ff <= rd_data;
         if (rd_data < mn_ff) mn_ff <= rd_data;
      end else if (ctl.acc2) begin
         sq_ff <= sq_ff + SQ_W'(dsq);
      end
      if (ctl.mean_calc) begin
         mean_ff <= RANGE_W'(sum_ff / WINDOW_LEN);
      end
   end

   // mean squared deviation divided by constant length; values < 2^28
   logic [SQ_W-1:0] msd;
   assign msd = sq_ff / WINDOW_LEN;

   // --- bit-serial isqrt ----------------------------------------------
   logic [2*SQRT_W-1:0] sv_ff, sres_ff, sbit_ff;
   logic [2*SQRT_W-1:0] stry;
   assign stry = sres_ff + sbit_ff;
   always_ff @(posedge clock) begin
      if (ctl.sq_div) begin
         sv_ff   <= (2*SQRT_W)'(msd);
         sres_ff <= '0;
         sbit_ff <= (2*SQRT_W)'(1) << (2*SQRT_W - 2);
      end else if (ctl.sqrt_step) begin
         if (sv_ff >= stry) begin
            sv_ff   <= sv_ff - stry;
            sres_ff <= (sres_ff >> 1) + sbit_ff;
         end else begin
            sres_ff <= sres_ff >> 1;
         end
         sbit_ff <= sbit_ff >> 2;
      end
   end

   // --- result register -----------------------------------------------
   logic [RANGE_W-1:0] cl;
   assign cl = (med_ff > CLAMP_HI) ? CLAMP_HI : ((med_ff < CLAMP_LO) ? CLAMP_LO : med_ff);
   always_ff @(posedge clock) begin
      if (ctl.out_load) begin
         range_clamped <= cl[CLAMP_W-1:0];
         window_mean   <= mean_ff;
         window_spread <= mx_ff - mn_ff;
         window_stdev  <= sres_ff[STDEV_W-1:0];
      end
   end
endmodule

// File: hdl/irmw_ctrl.sv
// ----------------------------------------------------------------------------
// irmw_ctrl: sequencing state machine
// Clears the window after reset, then steps each word through the datapath.
// ----------------------------------------------------------------------------
module irmw_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   output logic              out_valid,
   input  logic              out_ready,
   output irmw_pkg::ctl_type ctl,
   input  irmw_pkg::sts_type sts
);
   import irmw_pkg::*;

   localparam logic [3:0] ST_CLR   = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_DIV   = 4'd2;
   localparam logic [3:0] ST_MED   = 4'd3;
   localparam logic [3:0] ST_P1    = 4'd4;
   localparam logic [3:0] ST_MEAN  = 4'd5;
   localparam logic [3:0] ST_P2    = 4'd6;
   localparam logic [3:0] ST_SQDIV = 4'd7;
   localparam logic [3:0] ST_SQRT  = 4'd8;
   localparam logic [3:0] ST_OUT   = 4'd9;
   localparam logic [3:0] ST_WAIT  = 4'd10;

   logic [3:0] state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic       last_ff, last_in;  // read data of the final entry is pending
   logic       ov_ff, ov_in;

   assign in_ready  = (state_ff == ST_IDLE);
   assign out_valid = ov_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      last_in  = 1'b0;
      ov_in    = ov_ff;
      ctl      = '0;
      if (ov_ff && out_ready) ov_in = 1'b0;
      case (state_ff)
         ST_CLR: begin
            ctl.clr_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (sts.rd_last) begin
               state_in = ST_IDLE;
            end
            ctl.rd_issue = 1'b1;
         end
         ST_IDLE: begin
            if (in_valid) begin
               ctl.load = 1'b1;
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            ctl.div_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 5'd16) state_in = ST_MED;
         end
         ST_MED: begin
            ctl.median      = 1'b1;
            ctl.rd_addr_clr = 1'b1;
            ctl.acc_clr     = 1'b1;
            state_in        = ST_P1;
            cnt_in          = '0;
         end
         ST_P1, ST_P2: begin
            // first cycle only issues the read; then accumulate each entry
            ctl.rd_issue = 1'b1;
            last_in = sts.rd_last;
            if (cnt_ff != '0) begin
               ctl.acc1 = (state_ff == ST_P1);
               ctl.acc2 = (state_ff == ST_P2);
            end
            cnt_in = 5'd1;
            if (last_ff) begin
               ctl.rd_issue = 1'b0;
               state_in = (state_ff == ST_P1) ? ST_MEAN : ST_SQDIV;
            end
         end
         ST_MEAN: begin
            ctl.mean_calc = 1'b1;
            cnt_in   = '0;
            state_in = ST_P2;
         end
         ST_SQDIV: begin
            ctl.sq_div = 1'b1;
            cnt_in   = '0;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            ctl.sqrt_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 5'd13) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!ov_ff || out_ready) begin
               ctl.out_load = 1'b1;
               ov_in    = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLR;
         cnt_ff   <= '0;
         last_ff  <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         last_ff  <= last_in;
         ov_ff    <= ov_in;
      end
   end
endmodule

// File: hdl/ir_range_median_window_stats.sv
// ----------------------------------------------------------------------------
// ir_range_median_window_stats: IR range filter with window statistics
// Converts ADC words to range, median-of-3 filters and reports window stats.
// ----------------------------------------------------------------------------
// Usage:
//   req  : one 10-bit raw ADC word per handshake (valid/ready).
//   rsp  : one word per request: clamped median range, window mean,
//          window spread and window standard deviation.
// Flow: an accepted word passes through the bit-serial divider, the
//   median/write step, two passes over the window through the single
//   read port of the window RAM, the mean step, the divide step, the
//   square-root steps and the output step that loads the result register.
//   One word is in flight at a time; req_ready rises again as soon as
//   the result is loaded, even if rsp has not yet been taken.
// Reset: synchronous; the window RAM is then cleared one entry a cycle,
//   with req_ready low. Median taps start at zero.
// Stall: a result waiting on rsp_ready holds; the next word may be
//   processed but its result waits until the register is free.
// ----------------------------------------------------------------------------
module ir_range_median_window_stats #(
   parameter int WINDOW_LEN = irmw_pkg::WINDOW_LEN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   irmw_req_if.sink    req,
   irmw_rsp_if.source  rsp
);
   import irmw_pkg::*;

   ctl_type ctl;
   sts_type sts;

   irmw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .ctl       (ctl),
      .sts       (sts)
   );

   irmw_datapath #(.WINDOW_LEN(WINDOW_LEN)) u_dp (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .sts           (sts),
      .raw_sample    (req.raw_sample),
      .range_clamped (rsp.range_clamped),
      .window_mean   (rsp.window_mean),
      .window_spread (rsp.window_spread),
      .window_stdev  (rsp.window_stdev)
   );

   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.range_clamped >= 7'd10 && rsp.range_clamped <= 7'd80))
      else $error("clamped range out of bounds");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl.load, ctl.div_step, ctl.median, ctl.sqrt_step, ctl.out_load}))
      else $error("conflicting datapath commands");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      ctl.div_step |-> !req.ready)
      else $error("input accepted while busy");
endmodule
